### src/bfop_pkg.sv
// Shared types, constants and codes of the bounded FIFO with overflow policy.
package bfop_pkg;

    localparam int DEPTH = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int EVT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_CLOSE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED      = 3'd0,
        ST_ACCEPTED_DROP = 3'd1,
        ST_REJ_FULL      = 3'd2,
        ST_REJ_CLOSED    = 3'd3,
        ST_POPPED        = 3'd4,
        ST_POP_EMPTY     = 3'd5,
        ST_DONE          = 3'd6
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MODE = 2'd1;

    typedef struct packed {
        req_t              req_type;
        logic [DATA_W-1:0] frame_data;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [DATA_W-1:0] pop_data;
        logic [CNT_W-1:0]  occupancy;
        logic              is_closed;
        logic [EVT_W-1:0]  accepted_count;
        logic [EVT_W-1:0]  dropped_count;
        logic [EVT_W-1:0]  full_reject_count;
        logic [EVT_W-1:0]  closed_reject_count;
    } out_item_t;

    typedef struct packed {
        logic             shift;
        logic             write;
        logic [IDX_W-1:0] wr_idx;
    } cell_ctl_t;

endpackage

### src/bfop_cell.sv
// One storage cell of the FIFO chain: loads the new word, takes its neighbor's word or holds its own.
module bfop_cell
    import bfop_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [IDX_W-1:0]  cell_idx,
    input  logic [DATA_W-1:0] frame_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.write && (ctl.wr_idx == cell_idx))
        begin
            data_next = frame_data;
        end
        else if (ctl.shift)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/bfop_ctrl.sv
// Occupancy, closed flag, event counters, registers and result of each item.
module bfop_ctrl
    import bfop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  in_item_t              item,
    input  logic [DATA_W-1:0]     head_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cell_ctl_t             ctl,
    output out_item_t             result
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic [EVT_W-1:0] acc_reg, acc_next;
    logic [EVT_W-1:0] drop_reg, drop_next;
    logic [EVT_W-1:0] full_reg, full_next;
    logic [EVT_W-1:0] crej_reg, crej_next;
    logic [CNT_W-1:0] limit_reg;
    logic             mode_reg;
    logic [CNT_W-1:0] eff_limit;
    logic             is_full;
    status_t          status;
    logic [DATA_W-1:0] pop_data;

    always_comb
    begin
        if (limit_reg == '0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (limit_reg > CNT_W'(DEPTH))
        begin
            eff_limit = CNT_W'(DEPTH);
        end
        else
        begin
            eff_limit = limit_reg;
        end
    end

    assign is_full = (count_reg >= eff_limit);

    always_comb
    begin
        count_next  = count_reg;
        closed_next = closed_reg;
        acc_next    = acc_reg;
        drop_next   = drop_reg;
        full_next   = full_reg;
        crej_next   = crej_reg;
        status      = ST_DONE;
        pop_data    = '0;
        ctl         = '0;
        case (item.req_type)
            REQ_PUSH:
            begin
                if (closed_reg)
                begin
                    status = ST_REJ_CLOSED;
                    if (crej_reg != '1)
                    begin
                        crej_next = crej_reg + EVT_W'(1);
                    end
                end
                else if (is_full && !mode_reg)
                begin
                    status = ST_REJ_FULL;
                    if (full_reg != '1)
                    begin
                        full_next = full_reg + EVT_W'(1);
                    end
                end
                else
                begin
                    ctl.write = 1'b1;
                    if (acc_reg != '1)
                    begin
                        acc_next = acc_reg + EVT_W'(1);
                    end
                    if (is_full)
                    begin
                        status     = ST_ACCEPTED_DROP;
                        ctl.shift  = 1'b1;
                        ctl.wr_idx = IDX_W'(count_reg - CNT_W'(1));
                        if (drop_reg != '1)
                        begin
                            drop_next = drop_reg + EVT_W'(1);
                        end
                    end
                    else
                    begin
                        status     = ST_ACCEPTED;
                        ctl.wr_idx = IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            REQ_POP:
            begin
                if (count_reg == '0)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    status     = ST_POPPED;
                    pop_data   = head_data;
                    ctl.shift  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                closed_next = 1'b1;
            end
        endcase
        if (!fire)
        begin
            ctl = '0;
        end
    end

    assign result.status              = status;
    assign result.pop_data            = pop_data;
    assign result.occupancy           = count_next;
    assign result.is_closed           = closed_next;
    assign result.accepted_count      = acc_next;
    assign result.dropped_count       = drop_next;
    assign result.full_reject_count   = full_next;
    assign result.closed_reject_count = crej_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            closed_reg <= 1'b0;
            acc_reg    <= '0;
            drop_reg   <= '0;
            full_reg   <= '0;
            crej_reg   <= '0;
        end
        else if (fire)
        begin
            count_reg  <= count_next;
            closed_reg <= closed_next;
            acc_reg    <= acc_next;
            drop_reg   <= drop_next;
            full_reg   <= full_next;
            crej_reg   <= crej_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CNT_W'(DEPTH);
            mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_QUEUE_LIMIT)
            begin
                limit_reg <= CNT_W'(cfg_data);
            end
            else if (cfg_index == CFG_OVERFLOW_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
        end
    end

endmodule

### src/bounded_fifo_overflow_policy.sv
// Top level of the bounded FIFO with programmable limit and overflow policy.
//
//   Channel  Signals                                 Direction
//   in       in_valid, in_stall, in_item             request items in
//   out      out_valid, out_stall, out_item          result items out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register writes in
//
// Every item is handled when it is accepted and its result appears in the output
// register in the next cycle; one item per cycle is sustained while out_stall is low.
// The storage is a chain of cells with the oldest word in the first cell.
// The input stalls only while a result waits in the output register and out_stall is high.
// Reset clears occupancy, the closed flag, the counters and the overflow mode, and sets the limit to DEPTH.
module bounded_fifo_overflow_policy
    import bfop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              fire;
    cell_ctl_t         ctl;
    out_item_t         result;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign fire      = in_valid && !in_stall;

    bfop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item),
        .head_data (cell_data[0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .result    (result)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] right_data;
        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid
            assign right_data = cell_data[i + 1];
        end
        bfop_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .cell_idx   (IDX_W'(i)),
            .frame_data (in_item.frame_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### src/bfop_chk.sv
// Port-level checker of the bounded FIFO, bound to the top level.
module bfop_chk
    import bfop_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("A stalled result item changed or vanished.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("An accepted item gave no result in the next cycle.");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.occupancy <= CNT_W'(DEPTH))
        else $error("Occupancy exceeds the storage depth.");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_POP_EMPTY
        |-> out_item.pop_data == '0 && out_item.occupancy == '0)
        else $error("A pop on an empty FIFO returned data or occupancy.");

    a_closed_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_REJ_CLOSED |-> out_item.is_closed)
        else $error("A push was rejected as closed while the FIFO is open.");

endmodule

bind bounded_fifo_overflow_policy bfop_chk u_bfop_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

### tb/sv/tb_bounded_fifo_overflow_policy.sv
// Self-checking testbench for the bounded FIFO with a programmable limit and overflow mode.
`timescale 1ns / 1ps

module tb_bounded_fifo_overflow_policy;
    import bfop_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP = 10;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CLOSING_ITEMS = 60;
    localparam int N_PHASES = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int EV_ACCEPTED = 0;
    localparam int EV_DROPPED = 1;
    localparam int EV_FULL = 2;
    localparam int EV_CLOSED = 3;

    localparam logic [CFG_DATA_W-1:0] PHASE_LIMITS [N_PHASES] =
        '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5, 5'd16, 5'd3, 5'd15, 5'd1, 5'd12};
    localparam int PUSH_PCT [4] = '{70, 50, 30, 85};

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        in_item_t              item;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    typed;
        out_item_t             want;
    } plan_row_t;

    typedef struct {
        bit        typed;
        out_item_t want;
    } typed_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [DATA_W-1:0]     held_words [$];
    logic [EVT_W-1:0]      event_count [4] = '{default: '0};
    logic                  closed_now = 1'b0;
    logic [CFG_DATA_W-1:0] limit_reg = CFG_DATA_W'(DEPTH);
    logic                  mode_reg = 1'b0;

    out_item_t             expected_results [$];
    typed_result_t         typed_results [$];
    plan_row_t             plan [$];

    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;

    bounded_fifo_overflow_policy dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic void bump_event(int which);
        if (event_count[which] != '1)
        begin
            event_count[which]++;
        end
    endfunction

    function automatic out_item_t fifo_predict(in_item_t it);
        out_item_t r;
        int        lim;
        lim = (limit_reg == 0) ? 1 : (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
        r = '0;
        r.status = ST_DONE;
        case (it.req_type)
            REQ_PUSH:
            begin
                if (closed_now)
                begin
                    bump_event(EV_CLOSED);
                    r.status = ST_REJ_CLOSED;
                end
                else if (held_words.size() >= lim && !mode_reg)
                begin
                    bump_event(EV_FULL);
                    r.status = ST_REJ_FULL;
                end
                else
                begin
                    r.status = ST_ACCEPTED;
                    if (held_words.size() >= lim)
                    begin
                        held_words.delete(0);
                        bump_event(EV_DROPPED);
                        r.status = ST_ACCEPTED_DROP;
                    end
                    held_words = {held_words, it.frame_data};
                    bump_event(EV_ACCEPTED);
                end
            end
            REQ_POP:
            begin
                if (held_words.size() == 0)
                begin
                    r.status = ST_POP_EMPTY;
                end
                else
                begin
                    r.pop_data = held_words[0];
                    held_words.delete(0);
                    r.status = ST_POPPED;
                end
            end
            REQ_CLEAR:
            begin
                held_words.delete();
            end
            default:
            begin
                closed_now = 1'b1;
            end
        endcase
        r.occupancy = CNT_W'(held_words.size());
        r.is_closed = closed_now;
        r.accepted_count = event_count[EV_ACCEPTED];
        r.dropped_count = event_count[EV_DROPPED];
        r.full_reject_count = event_count[EV_FULL];
        r.closed_reject_count = event_count[EV_CLOSED];
        return r;
    endfunction

    function automatic out_item_t result_of(status_t st, logic [DATA_W-1:0] pd, int occ,
                                            logic cl, int acc, int drp, int full, int clsd);
        out_item_t r;
        r.status = st;
        r.pop_data = pd;
        r.occupancy = CNT_W'(occ);
        r.is_closed = cl;
        r.accepted_count = EVT_W'(acc);
        r.dropped_count = EVT_W'(drp);
        r.full_reject_count = EVT_W'(full);
        r.closed_reject_count = EVT_W'(clsd);
        return r;
    endfunction

    function automatic void plan_item(req_t rq, logic [DATA_W-1:0] d, bit typed = 1'b0,
                                      out_item_t w = '0);
        plan_row_t row;
        row.kind = ROW_ITEM;
        row.item.req_type = rq;
        row.item.frame_data = d;
        row.idx = '0;
        row.val = '0;
        row.typed = typed;
        row.want = w;
        plan = {plan, row};
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row.kind = ROW_CFG;
        row.item = '0;
        row.idx = idx;
        row.val = val;
        row.typed = 1'b0;
        row.want = '0;
        plan = {plan, row};
    endfunction

    function automatic in_item_t draw_request(int push_pct, bit allow_close);
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: it.frame_data = '0;
            1: it.frame_data = '1;
            2: it.frame_data = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            3: it.frame_data = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            default: it.frame_data = $urandom;
        endcase
        if (pick < 3)
        begin
            it.req_type = REQ_CLEAR;
        end
        else if (allow_close && pick < 6)
        begin
            it.req_type = REQ_CLOSE;
        end
        else if (pick < 6 + push_pct)
        begin
            it.req_type = REQ_PUSH;
        end
        else
        begin
            it.req_type = REQ_POP;
        end
        return it;
    endfunction

    task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic send_request(in_item_t it, bit typed, out_item_t want);
        int            gap;
        typed_result_t tr;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        tr.typed = typed;
        tr.want = want;
        typed_results = {typed_results, tr};
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        out_item_t     pred;
        out_item_t     want;
        typed_result_t typed;
        bit            progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_QUEUE_LIMIT: limit_reg = cfg_data;
                    CFG_OVERFLOW_MODE: mode_reg = cfg_data[0];
                    default: ;
                endcase
                cfg_writes++;
                progress = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                pred = fifo_predict(in_item);
                typed = typed_results[0];
                typed_results.delete(0);
                want = typed.typed ? typed.want : pred;
                expected_results = {expected_results, want};
                progress = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %h", $time, out_item);
                    mismatches++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("status", 64'(want.status), 64'(out_item.status));
                    check_field("pop_data", 64'(want.pop_data), 64'(out_item.pop_data));
                    check_field("occupancy", 64'(want.occupancy), 64'(out_item.occupancy));
                    check_field("is_closed", 64'(want.is_closed), 64'(out_item.is_closed));
                    check_field("accepted_count", 64'(want.accepted_count),
                                64'(out_item.accepted_count));
                    check_field("dropped_count", 64'(want.dropped_count),
                                64'(out_item.dropped_count));
                    check_field("full_reject_count", 64'(want.full_reject_count),
                                64'(out_item.full_reject_count));
                    check_field("closed_reject_count", 64'(want.closed_reject_count),
                                64'(out_item.closed_reject_count));
                    results_checked++;
                end
                progress = 1'b1;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                n = HOLD_OFF_CYCLES;
            end
            else
            begin
                n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int       ph;
        int       i;
        in_item_t it;

        plan_item(REQ_POP, 32'h0000_0000, 1'b1, result_of(ST_POP_EMPTY, 0, 0, 0, 0, 0, 0, 0));
        plan_item(REQ_PUSH, 32'h0000_0000, 1'b1, result_of(ST_ACCEPTED, 0, 1, 0, 1, 0, 0, 0));
        plan_item(REQ_PUSH, 32'hFFFF_FFFF, 1'b1, result_of(ST_ACCEPTED, 0, 2, 0, 2, 0, 0, 0));
        plan_item(REQ_POP, 32'h1234_5678, 1'b1, result_of(ST_POPPED, 0, 1, 0, 2, 0, 0, 0));
        plan_item(REQ_POP, 32'h0000_0000, 1'b1,
                  result_of(ST_POPPED, 32'hFFFF_FFFF, 0, 0, 2, 0, 0, 0));
        plan_reg(CFG_QUEUE_LIMIT, 5'd0);
        plan_item(REQ_PUSH, 32'h8000_0001, 1'b1, result_of(ST_ACCEPTED, 0, 1, 0, 3, 0, 0, 0));
        plan_item(REQ_PUSH, 32'h7FFF_FFFE, 1'b1, result_of(ST_REJ_FULL, 0, 1, 0, 3, 0, 1, 0));
        plan_reg(CFG_OVERFLOW_MODE, 5'd1);
        plan_item(REQ_PUSH, 32'h0000_FFFF);
        plan_reg(CFG_QUEUE_LIMIT, 5'd3);
        plan_item(REQ_PUSH, 32'hDEAD_BEEF);
        plan_item(REQ_PUSH, 32'h0123_4567);
        plan_reg(CFG_QUEUE_LIMIT, 5'd1);
        plan_item(REQ_PUSH, 32'h89AB_CDEF);
        plan_reg(CFG_OVERFLOW_MODE, 5'd0);
        plan_item(REQ_PUSH, 32'h5555_5555, 1'b1, result_of(ST_REJ_FULL, 0, 3, 0, 7, 2, 2, 0));
        plan_item(REQ_POP, 32'h0000_0000);
        plan_item(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, result_of(ST_DONE, 0, 0, 0, 7, 2, 2, 0));
        plan_reg(CFG_SPARE_2, 5'd31);
        plan_reg(CFG_SPARE_3, 5'd16);
        plan_item(REQ_PUSH, 32'hAAAA_AAAA);
        plan_item(REQ_PUSH, 32'h3333_3333);
        plan_reg(CFG_QUEUE_LIMIT, 5'd31);
        plan_item(REQ_PUSH, 32'hCCCC_CCCC);
        plan_item(REQ_POP, 32'hFFFF_FFFF);
        plan_item(REQ_CLEAR, 32'h0000_0000);
        plan_item(REQ_POP, 32'h0000_0000, 1'b1, result_of(ST_POP_EMPTY, 0, 0, 0, 9, 2, 3, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (i > 0 && plan[i - 1].kind == ROW_ITEM)
                begin
                    wait_idle();
                end
                write_reg(plan[i].idx, plan[i].val);
                if (i + 1 == plan.size() || plan[i + 1].kind != ROW_CFG)
                begin
                    cfg_valid <= 1'b0;
                end
            end
            else
            begin
                send_request(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // The FIFO keeps its contents across phases, so a lower limit meets a fuller store.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            write_reg(CFG_QUEUE_LIMIT, PHASE_LIMITS[ph]);
            if (ph < 7)
            begin
                write_reg(CFG_OVERFLOW_MODE, CFG_DATA_W'(ph % 2));
            end
            else
            begin
                write_reg(CFG_OVERFLOW_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            end
            if (ph % 4 == 1)
            begin
                write_reg(ph % 8 == 1 ? CFG_SPARE_2 : CFG_SPARE_3, CFG_DATA_W'($urandom));
            end
            cfg_valid <= 1'b0;
            no_idle = (ph == 4 || ph == 9);
            if (ph == 2)
            begin
                hold_off_req = 1'b1;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 6 && i == ITEMS_PER_PHASE / 2)
                begin
                    wait_idle();
                end
                send_request(draw_request(PUSH_PCT[ph % 4], 1'b0), 1'b0, '0);
            end
        end

        // Closing is permanent, so it is left for the last phase.
        wait_idle();
        write_reg(CFG_QUEUE_LIMIT, 5'd2);
        write_reg(CFG_OVERFLOW_MODE, 5'd0);
        cfg_valid <= 1'b0;
        no_idle = 1'b0;
        for (i = 0; i < 5; i++)
        begin
            it = draw_request(0, 1'b0);
            it.req_type = (i == 3) ? REQ_CLOSE : REQ_PUSH;
            send_request(it, 1'b0, '0);
        end
        for (i = 0; i < CLOSING_ITEMS; i++)
        begin
            send_request(draw_request(50, 1'b1), 1'b0, '0);
        end

        wait_idle();
        repeat (4) @(posedge clk);

        $display("Checked %0d results of %0d requests (%0d directed) over %0d register writes.",
                 results_checked, items_sent, plan.size() - 8, cfg_writes);
        $display("Pushes accepted %0d, oldest dropped %0d, rejected full %0d, rejected closed %0d.",
                 event_count[EV_ACCEPTED], event_count[EV_DROPPED], event_count[EV_FULL],
                 event_count[EV_CLOSED]);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
